// ===== rtl/tba_pkg.sv =====
// Shared types, constants and helpers for the tick bar aggregator.
package tba_pkg;

    localparam int unsigned SYMBOL_SLOTS_DEF = 256;
    localparam int unsigned PRICE_BITS_DEF   = 32;
    localparam logic [15:0] PERIOD_RESET     = 16'd100;
    localparam int unsigned US_PER_MS        = 1000;
    localparam int unsigned DIV_BITS         = 64;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [31:0] VOL_MAX          = 32'hFFFF_FFFF;
    localparam logic [47:0] SUM48_MAX        = 48'hFFFF_FFFF_FFFF;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CHECK,
        ST_DIV_VWAP,
        ST_START_BID,
        ST_DIV_BID,
        ST_START_ASK,
        ST_DIV_ASK,
        ST_OUT
    } state_t;

    // Which quotient the divider works on.
    typedef enum logic [1:0] {
        DSEL_VWAP,
        DSEL_BID,
        DSEL_ASK
    } div_sel_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic     capture;     // latch the accepted request
        logic     mem_read;    // read the slot entry
        logic     update;      // fold the tick and write back
        logic     div_start;   // load the divider
        div_sel_t div_sel;
        logic     div_store;   // store the finished quotient
        logic     out_load;    // load the output register
    } tba_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic in_range;
        logic close_bar;
        logic div_done;
    } tba_stat_t;

    // Clamp a 64-bit quotient to 32 bits.
    function automatic logic [31:0] sat32(input logic [63:0] v);
        sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

// ===== rtl/tba_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module tba_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [tba_pkg::DIV_BITS-1:0]    dividend,
    input  logic [tba_pkg::DIV_BITS-1:0]    divisor,
    output logic                            done,
    output logic [tba_pkg::DIV_BITS-1:0]    quotient
);

    localparam int unsigned CW = $clog2(tba_pkg::DIV_BITS + 1);

    logic [tba_pkg::DIV_BITS-1:0] quo_reg, quo_next;
    logic [tba_pkg::DIV_BITS-1:0] rem_reg, rem_next;
    logic [tba_pkg::DIV_BITS-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic [tba_pkg::DIV_BITS:0]   trial;

    // Shift one dividend bit in and trial subtract.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[tba_pkg::DIV_BITS-1]} - {1'b0, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(tba_pkg::DIV_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[tba_pkg::DIV_BITS]) begin
                rem_next = trial[tba_pkg::DIV_BITS-1:0];
                quo_next = {quo_reg[tba_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[tba_pkg::DIV_BITS-2:0], quo_reg[tba_pkg::DIV_BITS-1]};
                quo_next = {quo_reg[tba_pkg::DIV_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = busy_reg && (cnt_reg == CW'(1));
    assign quotient = quo_next;

endmodule

// ===== rtl/tba_datapath.sv =====
// Slot table, tick fold, close test, divider and output register.
module tba_datapath #(
    parameter int unsigned SYMBOL_SLOTS = tba_pkg::SYMBOL_SLOTS_DEF,
    parameter int unsigned PRICE_BITS   = tba_pkg::PRICE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tba_pkg::tba_cmd_t   cmd,
    output tba_pkg::tba_stat_t  stat,
    input  logic [15:0]         bar_period,
    input  logic [7:0]          s_symbol_index,
    input  logic [63:0]         s_tick_time_us,
    input  logic [63:0]         s_now_us,
    input  logic [31:0]         s_price,
    input  logic [31:0]         s_volume,
    input  logic [31:0]         s_bid,
    input  logic [31:0]         s_ask,
    output logic [7:0]          m_bar_symbol,
    output logic [63:0]         m_bar_time_us,
    output logic [31:0]         m_open_price,
    output logic [31:0]         m_close_price,
    output logic [31:0]         m_high_price,
    output logic [31:0]         m_low_price,
    output logic [31:0]         m_vwap,
    output logic [31:0]         m_total_volume,
    output logic [31:0]         m_mean_bid,
    output logic [31:0]         m_mean_ask,
    output logic [15:0]         m_tick_count
);

    localparam int unsigned AW = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
    localparam logic [31:0] PMASK = 32'((64'd1 << PRICE_BITS) - 64'd1);

    // Entry layout: start, first, latest, max, min, pv, vol, bid, ask, count.
    typedef struct packed {
        logic [63:0] start_time;
        logic [31:0] first_price;
        logic [31:0] latest_price;
        logic [31:0] max_price;
        logic [31:0] min_price;
        logic [63:0] pv_sum;
        logic [31:0] vol_sum;
        logic [47:0] bid_sum;
        logic [47:0] ask_sum;
        logic [15:0] ticks;
    } entry_t;

    entry_t             mem [SYMBOL_SLOTS];
    logic [SYMBOL_SLOTS-1:0] open_reg;
    entry_t             rd_reg;
    entry_t             upd_reg, upd_next;
    logic               was_open_reg;

    logic [7:0]  sym_reg;
    logic [63:0] tick_reg, now_reg;
    logic [31:0] price_reg, vol_reg, bid_reg, ask_reg;
    logic [63:0] prod_reg;
    logic [31:0] period_us_reg;
    logic [AW-1:0] addr;
    logic          close_reg;
    logic          in_range;
    logic          div_done;

    assign addr = AW'(sym_reg);

    // Latch the accepted request and form the product.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sym_reg   <= s_symbol_index;
            tick_reg  <= s_tick_time_us;
            now_reg   <= s_now_us;
            price_reg <= s_price & PMASK;
            vol_reg   <= s_volume;
            bid_reg   <= s_bid & PMASK;
            ask_reg   <= s_ask & PMASK;
            prod_reg  <= 64'(s_price & PMASK) * 64'(s_volume);
            period_us_reg <= 32'(bar_period) * 32'(tba_pkg::US_PER_MS);
        end
    end

    assign in_range = (32'(sym_reg) < 32'(SYMBOL_SLOTS));

    // Read the entry.
    always_ff @(posedge aclk) begin
        if (cmd.mem_read) begin
            rd_reg       <= mem[addr];
            was_open_reg <= open_reg[addr];
        end
    end

    // Fold the tick into the entry.
    always_comb begin
        entry_t      b;
        logic [64:0] pv;
        logic [32:0] vs;
        logic [48:0] bs, as_;
        b = rd_reg;
        if (!was_open_reg) begin
            b.start_time  = tick_reg;
            b.first_price = price_reg;
            b.max_price   = price_reg;
            b.min_price   = price_reg;
            b.pv_sum      = '0;
            b.vol_sum     = '0;
            b.bid_sum     = '0;
            b.ask_sum     = '0;
            b.ticks       = '0;
        end
        upd_next = b;
        upd_next.latest_price = price_reg;
        if (price_reg > b.max_price) upd_next.max_price = price_reg;
        if (price_reg < b.min_price) upd_next.min_price = price_reg;
        pv  = {1'b0, b.pv_sum} + {1'b0, prod_reg};
        vs  = {1'b0, b.vol_sum} + {1'b0, vol_reg};
        bs  = {1'b0, b.bid_sum} + 49'(bid_reg);
        as_ = {1'b0, b.ask_sum} + 49'(ask_reg);
        upd_next.pv_sum  = pv[64] ? '1 : pv[63:0];
        upd_next.vol_sum = vs[32] ? tba_pkg::VOL_MAX : vs[31:0];
        upd_next.bid_sum = bs[48] ? tba_pkg::SUM48_MAX : bs[47:0];
        upd_next.ask_sum = as_[48] ? tba_pkg::SUM48_MAX : as_[47:0];
        if (b.ticks != tba_pkg::COUNT_MAX) upd_next.ticks = b.ticks + 16'd1;
    end

    // Write back and register the close test.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= '0;
            close_reg <= 1'b0;
        end else if (cmd.update) begin
            close_reg     <= !((now_reg - upd_next.start_time) < 64'(period_us_reg));
            open_reg[addr] <= (now_reg - upd_next.start_time) < 64'(period_us_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            mem[addr] <= upd_next;
            upd_reg   <= upd_next;
        end
    end

    assign stat = '{in_range: in_range, close_bar: close_reg, div_done: div_done};

    // Divider operand selection.
    logic [63:0] dvd, dvs, quo;
    logic [31:0] vwap_reg, mbid_reg, mask_reg;
    always_comb begin
        case (cmd.div_sel)
            tba_pkg::DSEL_VWAP: begin
                dvd = upd_reg.pv_sum;
                dvs = 64'(upd_reg.vol_sum);
            end
            tba_pkg::DSEL_BID: begin
                dvd = 64'(upd_reg.bid_sum);
                dvs = 64'(upd_reg.ticks);
            end
            tba_pkg::DSEL_ASK: begin
                dvd = 64'(upd_reg.ask_sum);
                dvs = 64'(upd_reg.ticks);
            end
            default: begin
                dvd = '0;
                dvs = 64'd1;
            end
        endcase
    end

    tba_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    // Hold the quotients.
    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            case (cmd.div_sel)
                tba_pkg::DSEL_VWAP: vwap_reg <= (upd_reg.vol_sum == 32'd0) ?
                                                32'd0 : tba_pkg::sat32(quo);
                tba_pkg::DSEL_BID:  mbid_reg <= tba_pkg::sat32(quo);
                tba_pkg::DSEL_ASK:  mask_reg <= tba_pkg::sat32(quo);
                default: ;
            endcase
        end
    end

    // Load the output register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_bar_symbol   <= sym_reg;
            m_bar_time_us  <= now_reg;
            m_open_price   <= upd_reg.first_price;
            m_close_price  <= upd_reg.latest_price;
            m_high_price   <= upd_reg.max_price;
            m_low_price    <= upd_reg.min_price;
            m_vwap         <= vwap_reg;
            m_total_volume <= upd_reg.vol_sum;
            m_mean_bid     <= mbid_reg;
            m_mean_ask     <= mask_reg;
            m_tick_count   <= upd_reg.ticks;
        end
    end

endmodule

// ===== rtl/tba_ctrl.sv =====
// Controller state machine for the tick bar aggregator.
module tba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  tba_pkg::tba_stat_t  stat,
    output tba_pkg::tba_cmd_t   cmd
);

    tba_pkg::state_t state_reg, state_next;
    logic            mval_reg, mval_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tba_pkg::ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    // Sequence each request; output register frees on handshake.
    always_comb begin
        state_next    = state_reg;
        mval_next     = mval_reg;
        cmd           = '0;
        cmd.div_sel   = tba_pkg::DSEL_VWAP;
        s_ready       = 1'b0;
        if (mval_reg && m_ready) mval_next = 1'b0;
        case (state_reg)
            tba_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = tba_pkg::ST_READ;
                end
            end
            tba_pkg::ST_READ: begin
                if (stat.in_range) begin
                    cmd.mem_read = 1'b1;
                    state_next   = tba_pkg::ST_UPDATE;
                end else begin
                    state_next = tba_pkg::ST_IDLE;
                end
            end
            tba_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = tba_pkg::ST_CHECK;
            end
            // Start the first division on a closing bar, else drop back to idle
            tba_pkg::ST_CHECK: begin
                if (stat.close_bar) begin
                    cmd.div_start = 1'b1;
                    state_next    = tba_pkg::ST_DIV_VWAP;
                end else begin
                    state_next = tba_pkg::ST_IDLE;
                end
            end
            tba_pkg::ST_DIV_VWAP: begin
                cmd.div_sel = tba_pkg::DSEL_VWAP;
                if (stat.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = tba_pkg::ST_START_BID;
                end
            end
            tba_pkg::ST_START_BID: begin
                cmd.div_sel   = tba_pkg::DSEL_BID;
                cmd.div_start = 1'b1;
                state_next    = tba_pkg::ST_DIV_BID;
            end
            tba_pkg::ST_DIV_BID: begin
                cmd.div_sel = tba_pkg::DSEL_BID;
                if (stat.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = tba_pkg::ST_START_ASK;
                end
            end
            tba_pkg::ST_START_ASK: begin
                cmd.div_sel   = tba_pkg::DSEL_ASK;
                cmd.div_start = 1'b1;
                state_next    = tba_pkg::ST_DIV_ASK;
            end
            tba_pkg::ST_DIV_ASK: begin
                cmd.div_sel = tba_pkg::DSEL_ASK;
                if (stat.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = tba_pkg::ST_OUT;
                end
            end
            tba_pkg::ST_OUT: begin
                if (!mval_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mval_next    = 1'b1;
                    state_next   = tba_pkg::ST_IDLE;
                end
            end
            default: state_next = tba_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = mval_reg;

endmodule

// ===== rtl/tick_bar_aggregator_top.sv =====
// Ticks are latched, read, folded back and tested in turn; a tick off the table is
// dropped before the read. A closing bar runs three divisions on one shared radix-2
// divider, and the next tick is taken only once the bar enters the output register.
// The output register is separate, so a new tick is accepted while a bar waits.
// Synchronous active-low reset closes every slot and sets the bar period to 100 ms.
// Top level of the tick bar aggregator.
module tick_bar_aggregator_top #(
    parameter int unsigned SYMBOL_SLOTS = tba_pkg::SYMBOL_SLOTS_DEF,
    parameter int unsigned PRICE_BITS   = tba_pkg::PRICE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_symbol_index,
    input  logic [63:0] s_tick_time_us,
    input  logic [63:0] s_now_us,
    input  logic [31:0] s_price,
    input  logic [31:0] s_volume,
    input  logic [31:0] s_bid,
    input  logic [31:0] s_ask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_bar_symbol,
    output logic [63:0] m_bar_time_us,
    output logic [31:0] m_open_price,
    output logic [31:0] m_close_price,
    output logic [31:0] m_high_price,
    output logic [31:0] m_low_price,
    output logic [31:0] m_vwap,
    output logic [31:0] m_total_volume,
    output logic [31:0] m_mean_bid,
    output logic [31:0] m_mean_ask,
    output logic [15:0] m_tick_count
);

    logic [15:0]        period_reg;
    tba_pkg::tba_cmd_t  cmd;
    tba_pkg::tba_stat_t stat;

    // Hold the period register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= tba_pkg::PERIOD_RESET;
        end else if (cfg_valid) begin
            period_reg <= cfg_data;
        end
    end

    tba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tba_datapath #(
        .SYMBOL_SLOTS (SYMBOL_SLOTS),
        .PRICE_BITS   (PRICE_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .bar_period     (period_reg),
        .s_symbol_index (s_symbol_index),
        .s_tick_time_us (s_tick_time_us),
        .s_now_us       (s_now_us),
        .s_price        (s_price),
        .s_volume       (s_volume),
        .s_bid          (s_bid),
        .s_ask          (s_ask),
        .m_bar_symbol   (m_bar_symbol),
        .m_bar_time_us  (m_bar_time_us),
        .m_open_price   (m_open_price),
        .m_close_price  (m_close_price),
        .m_high_price   (m_high_price),
        .m_low_price    (m_low_price),
        .m_vwap         (m_vwap),
        .m_total_volume (m_total_volume),
        .m_mean_bid     (m_mean_bid),
        .m_mean_ask     (m_mean_ask),
        .m_tick_count   (m_tick_count)
    );

endmodule
